// ----- src/lemd_pkg.sv -----
`timescale 1ns / 1ps

package lemd_pkg;

  localparam int unsigned SampleWidth    = 10;
  localparam int unsigned ThresholdWidth = 10;
  localparam int unsigned CodeWidth      = 2;

  localparam logic [ThresholdWidth-1:0] ThresholdReset = ThresholdWidth'(5);

  // Edge class stored per sample
  typedef enum logic [1:0] {
    CLASS_FLAT = 2'd0,
    CLASS_RISE = 2'd1,
    CLASS_FALL = 2'd2
  } edge_class_e;

  // Reported marker code
  typedef enum logic [CodeWidth-1:0] {
    CODE_NONE     = 2'd0,
    CODE_MARKER   = 2'd1,
    CODE_POSSIBLE = 2'd2
  } marker_code_e;

endpackage

// ----- src/lemd_if.sv -----
`timescale 1ns / 1ps

interface lemd_sample_if;
  logic                            valid;
  logic                            ready;
  logic [lemd_pkg::SampleWidth-1:0] light_sample;

  modport source (output valid, output light_sample, input ready);
  modport sink   (input valid, input light_sample, output ready);
endinterface

interface lemd_code_if;
  logic                          valid;
  logic                          ready;
  logic [lemd_pkg::CodeWidth-1:0] marker_code;

  modport source (output valid, output marker_code, input ready);
  modport sink   (input valid, input marker_code, output ready);
endinterface

interface lemd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lemd_pkg::ThresholdWidth-1:0] edge_threshold;

  modport source (output valid, output edge_threshold, input ready);
  modport sink   (input valid, input edge_threshold, output ready);
endinterface

// ----- src/light_edge_marker_detector.sv -----
`timescale 1ns / 1ps
// Flow: an accepted sample is classified and written to the ring, the ring is scanned from the oldest
// entry, and the code then goes to the output register. The ring scan reads one entry per cycle
// through a single shared step unit, and stops early once a marker is found.
// The input is not ready while an item is being scanned or waits for the output register.
// Reset (rst_ni low, asynchronous): threshold 5, previous sample 0, all ring entries flat,
// pointer 0, no result pending.
module light_edge_marker_detector #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lemd_sample_if.sink       sample_i,
  lemd_code_if.source       code_o,
  lemd_cfg_if.sink          cfg_i
);
  import lemd_pkg::*;

  localparam int unsigned PW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [PW-1:0] LastIdx = PW'(WINDOW_LEN - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ThresholdWidth-1:0] thr_q;
  logic [SampleWidth-1:0]    prev_q;
  edge_class_e               ring_q [WINDOW_LEN];
  logic [PW-1:0]             ptr_q, ptr_next;
  logic [PW-1:0]             pos_q, pos_d;
  logic [PW-1:0]             cnt_q, cnt_d;
  logic                      last_rise_q, last_rise_d;
  logic                      last_fall_q, last_fall_d;
  logic                      rise_pair_q, rise_pair_d;
  logic                      fall_pair_q, fall_pair_d;
  marker_code_e              code_q, code_d;
  logic                      out_valid_q, out_valid_d;
  marker_code_e              out_code_q, out_code_d;

  logic                      in_acc;
  logic signed [SampleWidth+1:0] diff;
  logic signed [SampleWidth+1:0] thr_s;
  edge_class_e               new_class;
  edge_class_e               entry;
  logic                      scan_last;

  assign cfg_i.ready      = 1'b1;
  assign sample_i.ready   = (state_q == ST_IDLE);
  assign in_acc           = sample_i.valid && sample_i.ready;
  assign code_o.valid     = out_valid_q;
  assign code_o.marker_code = out_code_q;

  // Classify against the previous sample; a zero threshold makes a zero difference a rise
  assign diff  = $signed({2'b00, sample_i.light_sample}) - $signed({2'b00, prev_q});
  assign thr_s = $signed({2'b00, thr_q});

  always_comb begin
    if (diff >= thr_s) begin
      new_class = CLASS_RISE;
    end else if (diff <= -thr_s) begin
      new_class = CLASS_FALL;
    end else begin
      new_class = CLASS_FLAT;
    end
  end

  assign ptr_next = (ptr_q == LastIdx) ? '0 : ptr_q + PW'(1);
  assign entry    = ring_q[pos_q];

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    last_rise_d = last_rise_q;
    last_fall_d = last_fall_q;
    rise_pair_d = rise_pair_q;
    fall_pair_d = fall_pair_q;
    code_d      = code_q;
    out_code_d  = out_code_q;
    out_valid_d = out_valid_q && !code_o.ready;
    scan_last   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // Start at the oldest entry, just after the one written now
          pos_d       = ptr_next;
          cnt_d       = '0;
          last_rise_d = 1'b0;
          last_fall_d = 1'b0;
          rise_pair_d = 1'b0;
          fall_pair_d = 1'b0;
          code_d      = CODE_NONE;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        case (entry)
          CLASS_RISE: begin
            if (last_rise_q) begin
              if (fall_pair_q) begin
                code_d = CODE_MARKER;
              end else begin
                code_d      = CODE_POSSIBLE;
                rise_pair_d = 1'b1;
              end
            end
            last_rise_d = 1'b1;
            last_fall_d = 1'b0;
          end
          CLASS_FALL: begin
            if (last_fall_q) begin
              if (rise_pair_q) begin
                code_d = CODE_MARKER;
              end else begin
                code_d      = CODE_POSSIBLE;
                fall_pair_d = 1'b1;
              end
            end
            last_rise_d = 1'b0;
            last_fall_d = 1'b1;
          end
          default: begin
            last_rise_d = 1'b0;
            last_fall_d = 1'b0;
          end
        endcase
        scan_last = (code_d == CODE_MARKER) || (cnt_q == LastIdx);
        pos_d     = (pos_q == LastIdx) ? '0 : pos_q + PW'(1);
        cnt_d     = cnt_q + PW'(1);
        if (scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the code until the output register is free
        if (!out_valid_q || code_o.ready) begin
          out_valid_d = 1'b1;
          out_code_d  = code_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= ThresholdReset;
      prev_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_q[i] <= CLASS_FLAT;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        thr_q <= cfg_i.edge_threshold;
      end
      if (in_acc) begin
        ring_q[ptr_q] <= new_class;
        prev_q        <= sample_i.light_sample;
        ptr_q         <= ptr_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cnt_q       <= cnt_d;
    last_rise_q <= last_rise_d;
    last_fall_q <= last_fall_d;
    rise_pair_q <= rise_pair_d;
    fall_pair_q <= fall_pair_d;
    code_q      <= code_d;
    out_code_q  <= out_code_d;
  end

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LastIdx)
    else $error("ring pointer out of range");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SCAN))
    else $error("accepted item did not start a scan");

  a_scan_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !sample_i.ready && (cnt_q <= LastIdx))
    else $error("input ready or count overrun during scan");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_code_q == CODE_NONE || out_code_q == CODE_MARKER ||
                     out_code_q == CODE_POSSIBLE))
    else $error("illegal marker code");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import lemd_pkg::*;

  localparam int unsigned RingDepth  = 10;
  localparam int unsigned ScanCycles = RingDepth + 2;
  localparam int unsigned StallLimit = 2000;
  localparam int          SampleMax  = (1 << SampleWidth) - 1;

  typedef enum logic [1:0] {
    STEP_SAMPLE,
    STEP_THRESHOLD,
    STEP_DRAIN
  } step_kind_e;

  typedef struct packed {
    step_kind_e                 kind;
    logic [SampleWidth-1:0]     value;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_valid = 1'b0;
  logic [SampleWidth-1:0]    s_data = '0;
  logic                      c_valid = 1'b0;
  logic [ThresholdWidth-1:0] c_data = '0;
  logic                      r_ready = 1'b0;
  logic                      sample_taken = 1'b0;
  logic                      thr_taken = 1'b0;

  lemd_sample_if sample_ch ();
  lemd_code_if   code_ch ();
  lemd_cfg_if    thr_ch ();

  assign sample_ch.valid        = s_valid;
  assign sample_ch.light_sample = s_data;
  assign thr_ch.valid           = c_valid;
  assign thr_ch.edge_threshold  = c_data;
  assign code_ch.ready          = r_ready;

  light_edge_marker_detector #(
    .WINDOW_LEN(RingDepth)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_ch),
    .code_o  (code_ch),
    .cfg_i   (thr_ch)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor state
  logic [ThresholdWidth-1:0] thr_model = ThresholdReset;
  logic [SampleWidth-1:0]    last_sample = '0;
  edge_class_e               edge_hist[RingDepth];
  int unsigned               hist_ptr = 0;

  marker_code_e code_expected[$];
  step_t        script_q[$];

  int fail_count = 0;
  int n_samples = 0;
  int n_thresholds = 0;
  int n_codes[3] = '{0, 0, 0};
  int idle_cycles = 0;

  // Stimulus generator view of the block
  int gen_prev = 0;
  int gen_thr = ThresholdReset;

  initial begin
    for (int i = 0; i < RingDepth; i++) edge_hist[i] = CLASS_FLAT;
  end

  function automatic marker_code_e predict_marker(input logic [SampleWidth-1:0] s);
    int           diff;
    int           thr;
    int unsigned  pos;
    edge_class_e  cls;
    marker_code_e code;
    logic         last_rise, last_fall, rise_pair, fall_pair;

    diff = int'(s) - int'(last_sample);
    thr  = int'(thr_model);
    // rise test first: a zero threshold turns a zero difference into a rise
    if (diff >= thr) cls = CLASS_RISE;
    else if (diff <= -thr) cls = CLASS_FALL;
    else cls = CLASS_FLAT;
    edge_hist[hist_ptr] = cls;
    last_sample = s;

    code = CODE_NONE;
    last_rise = 1'b0;
    last_fall = 1'b0;
    rise_pair = 1'b0;
    fall_pair = 1'b0;
    pos = (hist_ptr + 1) % RingDepth;
    for (int n = 0; n < RingDepth; n++) begin
      case (edge_hist[pos])
        CLASS_RISE: begin
          if (last_rise) begin
            if (fall_pair) code = CODE_MARKER;
            else begin
              code = CODE_POSSIBLE;
              rise_pair = 1'b1;
            end
          end
          last_rise = 1'b1;
          last_fall = 1'b0;
        end
        CLASS_FALL: begin
          if (last_fall) begin
            if (rise_pair) code = CODE_MARKER;
            else begin
              code = CODE_POSSIBLE;
              fall_pair = 1'b1;
            end
          end
          last_rise = 1'b0;
          last_fall = 1'b1;
        end
        default: begin
          last_rise = 1'b0;
          last_fall = 1'b0;
        end
      endcase
      if (code == CODE_MARKER) break;
      pos = (pos + 1) % RingDepth;
    end

    hist_ptr = (hist_ptr + 1) % RingDepth;
    return code;
  endfunction

  // Long calm stretch in the middle of the run, otherwise about 9 in 100
  function automatic logic take_break();
    if (n_samples >= 400 && n_samples < 700) return 1'b0;
    return $urandom_range(99) < 9;
  endfunction

  // Pick a sample that lands in the wanted edge class where the range allows
  function automatic int shape_sample(input edge_class_e want_in, input int prev, input int thr);
    edge_class_e want;
    logic        up_ok, dn_ok;
    int          lo, hi;

    want  = want_in;
    up_ok = (prev + thr <= SampleMax);
    dn_ok = (prev - thr >= 0);
    if (want == CLASS_RISE && !up_ok) want = dn_ok ? CLASS_FALL : CLASS_FLAT;
    if (want == CLASS_FALL && !dn_ok) want = up_ok ? CLASS_RISE : CLASS_FLAT;
    case (want)
      CLASS_RISE: begin
        lo = prev + thr;
        hi = (lo + thr / 2 + 8 > SampleMax) ? SampleMax : lo + thr / 2 + 8;
      end
      CLASS_FALL: begin
        hi = prev - thr;
        lo = (hi - thr / 2 - 8 < 0) ? 0 : hi - thr / 2 - 8;
      end
      default: begin
        if (thr <= 1) return prev;
        lo = (prev - thr + 1 < 0) ? 0 : prev - thr + 1;
        hi = (prev + thr - 1 > SampleMax) ? SampleMax : prev + thr - 1;
      end
    endcase
    return $urandom_range(hi, lo);
  endfunction

  task automatic add_sample(input int v);
    step_t st;
    st.kind  = STEP_SAMPLE;
    st.value = v[SampleWidth-1:0];
    script_q.push_back(st);
    gen_prev = v;
  endtask

  task automatic add_threshold(input int v);
    step_t st;
    st.kind  = STEP_THRESHOLD;
    st.value = v[ThresholdWidth-1:0];
    script_q.push_back(st);
    gen_thr = v;
  endtask

  task automatic add_drain();
    step_t st;
    st.kind  = STEP_DRAIN;
    st.value = '0;
    script_q.push_back(st);
  endtask

  // Sender and receiver, both change on the falling edge
  always @(negedge clk_i) begin : drive
    logic                      nxt_s_valid, nxt_c_valid;
    logic [SampleWidth-1:0]    nxt_s_data;
    logic [ThresholdWidth-1:0] nxt_c_data;

    nxt_s_valid = s_valid && !sample_taken;
    nxt_s_data  = s_data;
    nxt_c_valid = c_valid && !thr_taken;
    nxt_c_data  = c_data;
    if (rst_ni && !nxt_s_valid && !nxt_c_valid && script_q.size() != 0) begin
      case (script_q[0].kind)
        STEP_SAMPLE: begin
          if (!take_break()) begin
            nxt_s_valid = 1'b1;
            nxt_s_data  = script_q[0].value;
            void'(script_q.pop_front());
          end
        end
        STEP_THRESHOLD: begin
          // write only once every result is back
          if (code_expected.size() == 0) begin
            nxt_c_valid = 1'b1;
            nxt_c_data  = script_q[0].value;
            void'(script_q.pop_front());
          end
        end
        default: begin
          if (code_expected.size() == 0) void'(script_q.pop_front());
        end
      endcase
    end
    s_valid <= nxt_s_valid;
    s_data  <= nxt_s_data;
    c_valid <= nxt_c_valid;
    c_data  <= nxt_c_data;
    r_ready <= !take_break();
  end

  // Monitor and scoreboard, sampled on the rising edge
  always @(posedge clk_i) begin : watch
    marker_code_e want;
    logic         s_fire, c_fire, r_fire;

    s_fire = rst_ni && sample_ch.valid && sample_ch.ready;
    c_fire = rst_ni && thr_ch.valid && thr_ch.ready;
    r_fire = rst_ni && code_ch.valid && code_ch.ready;
    sample_taken <= s_fire;
    thr_taken    <= c_fire;

    if (s_fire) begin
      code_expected.push_back(predict_marker(sample_ch.light_sample));
      n_samples++;
    end
    if (c_fire) begin
      thr_model = thr_ch.edge_threshold;
      n_thresholds++;
    end
    if (r_fire) begin
      if (code_expected.size() == 0) begin
        $error("marker_code: result %0d arrived with nothing expected", code_ch.marker_code);
        fail_count++;
      end else begin
        want = code_expected.pop_front();
        if (code_ch.marker_code !== want) begin
          $error("marker_code: expected %0d, actual %0d", want, code_ch.marker_code);
          fail_count++;
        end
        if (want <= CODE_POSSIBLE) n_codes[want]++;
      end
    end

    // watchdog on cycles with no item moving on any channel
    if (!rst_ni || s_fire || c_fire || r_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $error("no item moved for %0d cycles", StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    edge_class_e want_cls;
    int          run_len;
    int          phase_len;
    int          thr_pick;

    // Directed: reset threshold, exact +/- threshold steps, rise pair then fall pair
    add_sample(0);
    add_sample(SampleMax);
    add_sample(SampleMax);
    add_sample(0);
    add_sample(5);
    add_sample(10);
    add_sample(14);
    add_sample(9);
    add_sample(4);
    add_sample(0);
    // zero threshold: equal samples count as rises
    add_threshold(0);
    add_sample(0);
    add_sample(0);
    add_sample(3);
    add_sample(2);
    add_sample(1);
    // widest threshold: only full-scale swings are edges
    add_threshold(SampleMax);
    add_sample(0);
    add_sample(SampleMax);
    add_sample(0);
    add_sample(SampleMax);
    add_sample(SampleMax - 1);

    // Random phases, each behind a threshold write
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: thr_pick = 1;
        1: thr_pick = SampleMax;
        2: thr_pick = 0;
        default: thr_pick = ($urandom_range(99) < 70) ? $urandom_range(40, 1)
                                                      : $urandom_range(SampleMax, 1);
      endcase
      add_threshold(thr_pick);
      phase_len = $urandom_range(170, 130);
      while (phase_len > 0) begin
        case ($urandom_range(3))
          0: want_cls = CLASS_FLAT;
          1, 2: want_cls = CLASS_RISE;
          default: want_cls = CLASS_FALL;
        endcase
        if ($urandom_range(1) == 1 && want_cls == CLASS_RISE) want_cls = CLASS_FALL;
        run_len = $urandom_range(4, 1);
        for (int k = 0; k < run_len && phase_len > 0; k++) begin
          if ($urandom_range(99) < 15) add_sample($urandom_range(SampleMax));
          else add_sample(shape_sample(want_cls, gen_prev, gen_thr));
          phase_len--;
        end
        // hold the sender until every result is back
        if ($urandom_range(99) < 3) add_drain();
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (script_q.size() != 0 || code_expected.size() != 0 || s_valid || c_valid)
      @(posedge clk_i);
    repeat (3 * ScanCycles) @(posedge clk_i);

    $display("Covered %0d samples under %0d threshold writes (0, 1, 1023 and random).",
             n_samples, n_thresholds);
    $display("Codes seen: none %0d, marker %0d, possible marker %0d.",
             n_codes[CODE_NONE], n_codes[CODE_MARKER], n_codes[CODE_POSSIBLE]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
